### rtl/assert_macros.svh
// Assertion helpers for the profiler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks an implication on every clock edge, disabled during reset.
`define CHK_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Checks a next-cycle implication, disabled during reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/twtp_pkg.sv
// ----------------------------------------------------------------------------
// twtp_pkg
// Types and constants shared by the wheel track profiler modules.
// ----------------------------------------------------------------------------
package twtp_pkg;

  localparam logic [19:0] US_PER_S = 20'd1000000;

  typedef struct packed {
    logic [31:0]        sample_time;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [15:0] heading_sin;
    logic signed [15:0] heading_cos;
    logic               first_point;
  } twtp_in_t;

  typedef struct packed {
    logic signed [31:0] left_x;
    logic signed [31:0] left_y;
    logic [31:0]        left_travel;
    logic signed [31:0] left_speed;
    logic signed [31:0] left_accel;
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic [31:0]        right_travel;
    logic signed [31:0] right_speed;
    logic signed [31:0] right_accel;
    logic [31:0]        time_out;
    logic               zero_step_flag;
  } twtp_out_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE, ST_OFFS, ST_POINTS, ST_DELTA, ST_SQRT, ST_VMUL, ST_VDIV,
    ST_AMUL, ST_ADIV, ST_WNEXT, ST_DONE
  } twtp_state_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_OFFS, OP_POINTS, OP_DELTA, OP_SQ_INIT, OP_SQ_STEP,
    OP_VMUL, OP_DV_STEP, OP_VFIN, OP_AMUL, OP_AFIN, OP_WFIN, OP_COMMIT
  } twtp_op_t;

  typedef struct packed {
    twtp_op_t op;
    logic     wheel;   // 0 left, 1 right
  } twtp_cmd_t;

  typedef struct packed {
    logic first;
    logic dt_zero;
  } twtp_stat_t;

endpackage

### rtl/twtp_ctrl.sv
// ----------------------------------------------------------------------------
// twtp_ctrl
// Sequencer: steps the datapath through offsets, roots and divisions.
// ----------------------------------------------------------------------------
module twtp_ctrl import twtp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  twtp_stat_t stat,
  output twtp_cmd_t  cmd
);

  twtp_state_t state, state_next;
  logic [6:0]  cnt, cnt_next;
  logic        wheel, wheel_next;
  logic        busy;
  logic        skip;

  // The result register frees once the word is taken.
  assign busy     = out_valid && !out_ready;
  assign in_ready = (state == ST_IDLE);
  assign skip     = stat.first || stat.dt_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      wheel     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      wheel <= wheel_next;
      if (state == ST_DONE && !busy) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    wheel_next = wheel;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_OFFS;
      ST_OFFS:   state_next = ST_POINTS;
      ST_POINTS: begin
        wheel_next = 1'b0;
        state_next = stat.first ? ST_WNEXT : ST_DELTA;
      end
      ST_DELTA:  begin
        cnt_next   = '0;
        state_next = ST_SQRT;
      end
      ST_SQRT:   begin
        cnt_next = cnt + 7'd1;
        if (cnt == 7'd33) begin
          cnt_next   = '0;
          state_next = stat.dt_zero ? ST_WNEXT : ST_VMUL;
        end
      end
      ST_VMUL:   state_next = ST_VDIV;
      ST_VDIV:   begin
        cnt_next = cnt + 7'd1;
        if (cnt == 7'd66) begin
          cnt_next   = '0;
          state_next = ST_AMUL;
        end
      end
      ST_AMUL:   state_next = ST_ADIV;
      ST_ADIV:   begin
        cnt_next = cnt + 7'd1;
        if (cnt == 7'd66) begin
          cnt_next   = '0;
          state_next = ST_WNEXT;
        end
      end
      ST_WNEXT:  begin
        if (wheel || stat.first) state_next = ST_DONE;
        else begin
          wheel_next = 1'b1;
          state_next = ST_DELTA;
        end
      end
      ST_DONE:   if (!busy) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op    = OP_NONE;
    cmd.wheel = wheel;
    case (state)
      ST_IDLE:   if (in_valid) cmd.op = OP_LOAD;
      ST_OFFS:   cmd.op = OP_OFFS;
      ST_POINTS: cmd.op = OP_POINTS;
      ST_DELTA:  cmd.op = OP_DELTA;
      ST_SQRT:   cmd.op = (cnt == 7'd0) ? OP_SQ_INIT : OP_SQ_STEP;
      ST_VMUL:   cmd.op = OP_VMUL;
      ST_VDIV:   cmd.op = (cnt == 7'd66) ? OP_VFIN : OP_DV_STEP;
      ST_AMUL:   cmd.op = OP_AMUL;
      ST_ADIV:   cmd.op = (cnt == 7'd66) ? OP_AFIN : OP_DV_STEP;
      ST_WNEXT:  cmd.op = skip ? OP_WFIN : OP_NONE;
      ST_DONE:   if (!busy) cmd.op = OP_COMMIT;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

### rtl/twtp_dp.sv
// ----------------------------------------------------------------------------
// twtp_dp
// Datapath: offsets, shared bit-serial root and divider, per-wheel state.
// ----------------------------------------------------------------------------
module twtp_dp import twtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] wheel_base_width,
  input  twtp_in_t    in_data,
  input  twtp_cmd_t   cmd,
  output twtp_stat_t  stat,
  output twtp_out_t   out_data
);

  twtp_in_t           smp;
  logic [31:0]        dt;
  logic signed [33:0] ox, oy;
  logic signed [31:0] px [2], py [2], pspd [2];
  logic signed [31:0] nx [2], ny [2];
  logic [31:0]        psum [2], nsum [2];
  logic signed [31:0] vel [2], acc [2];
  logic [31:0]        prev_time;

  // Shared arithmetic registers.
  logic [65:0]        sq_val;     // radicand, consumed two bits a step
  logic [33:0]        root;
  logic [35:0]        rem;
  logic [65:0]        dnum;       // dividend magnitude shifted out
  logic [66:0]        drem;
  logic [65:0]        quot;
  logic               neg;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'sh7fffffff;
    if (v < -35'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [33:0] half_off(input logic [31:0] w,
                                                  input logic signed [15:0] t);
    logic [15:0] mag;
    logic [47:0] prod;
    logic [32:0] q;
    mag  = t[15] ? 16'(-t) : t;
    prod = w * mag;
    q    = 33'((prod + 48'h8000) >> 16);
    return t[15] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  logic [35:0]        trial;
  logic [35:0]        rem_sh;
  logic [66:0]        drem_sh;
  logic               w;
  logic signed [32:0] ddx, ddy, dvel;
  logic [31:0]        adx, ady, adv;
  logic [63:0]        sqx, sqy;

  assign w       = cmd.wheel;
  assign rem_sh  = {rem[33:0], sq_val[65:64]};
  assign trial   = {root, 2'b01};
  assign drem_sh = {drem[65:0], dnum[65]};
  assign stat.first   = smp.first_point;
  assign stat.dt_zero = (dt == 32'd0);

  // Every difference of two 32-bit values has a magnitude below 2^32.
  assign ddx  = 33'(nx[w]) - 33'(px[w]);
  assign ddy  = 33'(ny[w]) - 33'(py[w]);
  assign dvel = 33'(vel[w]) - 33'(pspd[w]);
  assign adx  = ddx[32] ? 32'(-ddx) : ddx[31:0];
  assign ady  = ddy[32] ? 32'(-ddy) : ddy[31:0];
  assign adv  = dvel[32] ? 32'(-dvel) : dvel[31:0];
  assign sqx  = dnum[31:0] * dnum[31:0];
  assign sqy  = drem[31:0] * drem[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        px[i] <= '0; py[i] <= '0; pspd[i] <= '0; psum[i] <= '0;
      end
      prev_time <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD:   begin
          smp <= in_data;
          dt  <= in_data.sample_time - prev_time;
        end
        OP_OFFS:   begin
          ox <= half_off(wheel_base_width, smp.heading_sin);
          oy <= half_off(wheel_base_width, smp.heading_cos);
        end
        OP_POINTS: begin
          nx[0] <= sat32(35'(smp.center_x) - 35'(ox));
          ny[0] <= sat32(35'(smp.center_y) + 35'(oy));
          nx[1] <= sat32(35'(smp.center_x) + 35'(ox));
          ny[1] <= sat32(35'(smp.center_y) - 35'(oy));
          for (int i = 0; i < 2; i++) begin
            vel[i] <= '0; acc[i] <= '0; nsum[i] <= '0;
          end
        end
        OP_DELTA:  begin
          // The delta magnitudes are parked in the divider registers.
          dnum <= 66'(adx);
          drem <= 67'(ady);
        end
        OP_SQ_INIT: begin
          sq_val <= 66'(sqx) + 66'(sqy);
          root   <= '0;
          rem    <= '0;
        end
        OP_SQ_STEP: begin
          sq_val <= {sq_val[63:0], 2'b00};
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[32:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[32:0], 1'b0};
          end
        end
        OP_VMUL:   begin
          nsum[w] <= (34'(psum[w]) + root > 34'hffffffff) ? 32'hffffffff :
                     32'(34'(psum[w]) + root);
          dnum    <= 66'(root) * 66'(US_PER_S);
          drem    <= '0;
          quot    <= '0;
          neg     <= 1'b0;
        end
        OP_DV_STEP: begin
          dnum <= {dnum[64:0], 1'b0};
          if (drem_sh >= 67'(dt)) begin
            drem <= drem_sh - 67'(dt);
            quot <= {quot[64:0], 1'b1};
          end else begin
            drem <= drem_sh;
            quot <= {quot[64:0], 1'b0};
          end
        end
        OP_VFIN:   vel[w] <= (quot > 66'h7fffffff) ? 32'sh7fffffff : quot[31:0];
        OP_AMUL:   begin
          neg  <= dvel[32];
          dnum <= 66'(adv) * 66'(US_PER_S);
          drem <= '0;
          quot <= '0;
        end
        OP_AFIN:   begin
          if (quot > 66'h7fffffff) acc[w] <= neg ? 32'sh80000000 : 32'sh7fffffff;
          else acc[w] <= neg ? -$signed(quot[31:0]) : $signed(quot[31:0]);
        end
        OP_WFIN:   if (!smp.first_point) begin
          nsum[w] <= (34'(psum[w]) + root > 34'hffffffff) ? 32'hffffffff :
                     32'(34'(psum[w]) + root);
        end
        OP_COMMIT: begin
          for (int i = 0; i < 2; i++) begin
            px[i] <= nx[i]; py[i] <= ny[i]; pspd[i] <= vel[i];
            psum[i] <= nsum[i];
          end
          prev_time <= smp.sample_time;
          out_data  <= '{left_x: nx[0], left_y: ny[0], left_travel: nsum[0],
                         left_speed: vel[0], left_accel: acc[0],
                         right_x: nx[1], right_y: ny[1], right_travel: nsum[1],
                         right_speed: vel[1], right_accel: acc[1],
                         time_out: smp.sample_time,
                         zero_step_flag: !smp.first_point && dt == 32'd0};
        end
        default: ;
      endcase
    end
  end

endmodule

### rtl/tank_wheel_track_profiler_core.sv
// ----------------------------------------------------------------------------
// tank_wheel_track_profiler_core
// Left and right wheel track, travel, speed and acceleration per sample.
// ----------------------------------------------------------------------------
// Usage: write wheel_base_width through cfg_we/cfg_data while idle. Samples
// enter on in_valid/in_ready; one result word leaves on out_valid/out_ready
// per sample. in_ready is high only while the block is idle, so one sample
// is in work at a time. Per wheel the shared datapath runs a 33-step
// bit-serial root and two 66-step bit-serial divisions; out_valid rises as
// the block returns to idle, where it can take the next sample. A first
// point skips the roots and divisions; a zero time step skips the divisions.
// The result register holds the word until it is taken; if the previous
// word is still waiting when a sample finishes, the block holds in its last
// state and takes no new sample. Reset clears the stored points, speeds,
// travel and time, wheel_base_width and out_valid, but not out_data.
// ----------------------------------------------------------------------------
module tank_wheel_track_profiler_core import twtp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  twtp_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output twtp_out_t   out_data
);
`include "assert_macros.svh"

  logic [31:0] wheel_base_width;
  twtp_cmd_t   cmd;
  twtp_stat_t  stat;

  always_ff @(posedge clk) begin
    if (rst) wheel_base_width <= '0;
    else if (cfg_we) wheel_base_width <= cfg_data;
  end

  twtp_ctrl u_ctrl (.clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
                    .stat, .cmd);
  twtp_dp u_dp (.clk, .rst, .wheel_base_width, .in_data, .cmd, .stat,
                .out_data);

  `CHK_NEXT(a_ready_drops, clk, rst, in_valid && in_ready, !in_ready,
            "accepted sample did not start work")
  `CHK_IMPL(a_load_idle, clk, rst, cmd.op == OP_LOAD, in_ready && in_valid,
            "load outside idle")
  `CHK_NEXT(a_commit_out, clk, rst, cmd.op == OP_COMMIT, out_valid,
            "commit without result")
endmodule
